[hdl/litm_pkg.sv]
// Package for the linebreak / indent token marker.
// Holds the mark kind codes, the mark and queue entry types, and the default sizes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package litm_pkg;

   localparam int POS_BITS_DEFAULT = 32;
   localparam int TAB_STOP_DEFAULT = 8;
   localparam int QUEUE_DEPTH      = 4;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam logic [15:0] IND_MAX = 16'hFFFF;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   localparam logic [2:0] KIND_NEWLINE   = 3'd0;
   localparam logic [2:0] KIND_PARAGRAPH = 3'd1;
   localparam logic [2:0] KIND_SECTION   = 3'd2;
   localparam logic [2:0] KIND_INDENT    = 3'd3;
   localparam logic [2:0] KIND_DEDENT    = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] start_pos;
      logic [15:0] mark_len;
      logic        special;
   } mark_type;

   // One byte's worth of marks: mark0 always, mark1 when two is set.
   typedef struct packed {
      logic     two;
      mark_type mark1;
      mark_type mark0;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage
`default_nettype wire

[hdl/litm_front.sv]
// Front end of the marker: accepts text bytes, keeps position, linebreak run
// and indentation state, and builds the marks of each byte. Uses litm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module litm_front #(
   parameter int POS_BITS = litm_pkg::POS_BITS_DEFAULT,
   parameter int TAB_STOP = litm_pkg::TAB_STOP_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          ch,
   input  wire logic                restart,
   output logic                     push,
   output litm_pkg::entry_type      entry
);

   localparam int CW = $clog2(TAB_STOP);
   localparam int DW = (POS_BITS > 17) ? POS_BITS : 17;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [CW-1:0] SAT_COL = CW'(65535 % TAB_STOP);
   localparam logic [CW-1:0] LAST_COL = CW'(TAB_STOP - 1);

   logic [POS_BITS-1:0] position_ff, position_in;
   logic [POS_BITS-1:0] run_start_ff, run_start_in;
   logic [1:0]          break_count_ff, break_count_in;
   logic [15:0]         indent_now_ff, indent_now_in;
   logic [15:0]         indent_prev_ff, indent_prev_in;
   logic [CW-1:0]       col_ff, col_in;   // indent_now modulo TAB_STOP

   logic [POS_BITS-1:0] p, rs_base;
   logic [1:0]          bc_base;
   logic [15:0]         ind_base, prev_base;
   logic [CW-1:0]       col_base;
   logic                brk, ws;
   logic [POS_BITS-1:0] diff;
   logic [DW-1:0]       diff_x;
   logic [15:0]         run_len;
   logic [16:0]         ind_step;

   always_comb begin
      // restart takes the reset values before this byte
      p         = restart ? '0 : position_ff;
      rs_base   = restart ? '0 : run_start_ff;
      bc_base   = restart ? 2'd1 : break_count_ff;
      ind_base  = restart ? '0 : indent_now_ff;
      prev_base = restart ? '0 : indent_prev_ff;
      col_base  = restart ? '0 : col_ff;

      brk = (ch == litm_pkg::CH_LF) || (ch == litm_pkg::CH_CR);
      ws  = brk || (ch == litm_pkg::CH_SPACE) || (ch == litm_pkg::CH_TAB);

      position_in    = (p == POS_MAX) ? p : p + 1'b1;
      run_start_in   = rs_base;
      break_count_in = bc_base;
      indent_now_in  = ind_base;
      indent_prev_in = prev_base;
      col_in         = col_base;

      push  = 1'b0;
      entry = '0;
      entry.mark0.start_pos = 32'(p);

      diff     = '0;
      diff_x   = '0;
      run_len  = '0;
      ind_step = '0;

      if (brk) begin
         push = 1'b1;
         entry.mark0.kind     = litm_pkg::KIND_NEWLINE;
         entry.mark0.mark_len = 16'd1;
         if (bc_base == 2'd0) begin
            run_start_in = p;
         end
         indent_now_in = '0;
         col_in        = '0;
         if (bc_base != 2'd3) begin
            break_count_in = bc_base + 2'd1;
         end
         diff   = p - run_start_in;
         diff_x = DW'(diff);
         if (p < run_start_in) begin
            run_len = '0;
         end else if (diff_x >= DW'(litm_pkg::LEN_MAX)) begin
            run_len = litm_pkg::LEN_MAX;
         end else begin
            run_len = 16'(diff_x + 1'b1);
         end
         entry.mark1.start_pos = 32'(run_start_in);
         entry.mark1.mark_len  = run_len;
         if (break_count_in == 2'd2) begin
            entry.two        = 1'b1;
            entry.mark1.kind = litm_pkg::KIND_PARAGRAPH;
         end else if (break_count_in == 2'd3) begin
            entry.two        = 1'b1;
            entry.mark1.kind = litm_pkg::KIND_SECTION;
         end
      end else if (ws && (bc_base != 2'd0)) begin
         if (ch == litm_pkg::CH_TAB) begin
            ind_step = {1'b0, ind_base} + 17'(TAB_STOP) - 17'(col_base);
            col_in   = '0;
         end else begin
            ind_step = {1'b0, ind_base} + 17'd1;
            col_in   = (col_base == LAST_COL) ? '0 : col_base + 1'b1;
         end
         if (ind_step > {1'b0, litm_pkg::IND_MAX}) begin
            indent_now_in = litm_pkg::IND_MAX;
            col_in        = SAT_COL;
         end else begin
            indent_now_in = ind_step[15:0];
         end
      end

      if (!ws && (bc_base != 2'd0)) begin
         entry.mark0.special = 1'b1;
         if (ind_base > prev_base) begin
            push = 1'b1;
            entry.mark0.kind = litm_pkg::KIND_INDENT;
         end else if (ind_base < prev_base) begin
            push = 1'b1;
            entry.mark0.kind = litm_pkg::KIND_DEDENT;
         end
         indent_prev_in = ind_base;
         break_count_in = 2'd0;
      end

      push = push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         run_start_ff   <= '0;
         break_count_ff <= 2'd1;
         indent_now_ff  <= '0;
         indent_prev_ff <= '0;
         col_ff         <= '0;
      end else if (accept) begin
         position_ff    <= position_in;
         run_start_ff   <= run_start_in;
         break_count_ff <= break_count_in;
         indent_now_ff  <= indent_now_in;
         indent_prev_ff <= indent_prev_in;
         col_ff         <= col_in;
      end
   end

endmodule
`default_nettype wire

[hdl/litm_queue.sv]
// Short queue of mark entries between the front and back ends.
// Register based, read at the head only. Uses litm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module litm_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire litm_pkg::entry_type  push_entry,
   input  wire logic                 pop,
   output litm_pkg::entry_type       head,
   output litm_pkg::q_status_type    status
);

   localparam int DEPTH = litm_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNW   = $clog2(DEPTH + 1);

   litm_pkg::entry_type slot_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0] count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CNW'(DEPTH));
      head         = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule
`default_nettype wire

[hdl/litm_back.sv]
// Back end of the marker: takes queue entries and sends their marks one per cycle
// while out_ready allows, through an output register, flagging the last. Uses litm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module litm_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire litm_pkg::entry_type    head,
   input  wire litm_pkg::q_status_type status,
   output logic                        pop,
   output logic                        out_valid,
   output litm_pkg::mark_type          out_mark,
   output logic                        out_last,
   input  wire logic                   out_ready
);

   logic               sel_ff, sel_in;       // 1: second mark of the head entry is next
   logic               valid_ff, valid_in;
   litm_pkg::mark_type mark_ff, mark_in;
   logic               last_ff, last_in;
   logic               load;

   always_comb begin
      load     = (!valid_ff || out_ready) && !status.empty;
      pop      = 1'b0;
      sel_in   = sel_ff;
      valid_in = valid_ff && !out_ready;
      mark_in  = mark_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         if (sel_ff) begin
            mark_in = head.mark1;
            last_in = 1'b1;
            pop     = 1'b1;
            sel_in  = 1'b0;
         end else begin
            mark_in = head.mark0;
            last_in = !head.two;
            pop     = !head.two;
            sel_in  = head.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mark_ff <= mark_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_mark  = mark_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire

[hdl/linebreak_indent_token_marker_core.sv]
// Top level of the linebreak / indent token marker.
// Instantiates litm_front, litm_queue and litm_back; uses litm_pkg.
//
// Usage: text bytes enter on the req_ stream, one byte per request, with a
// restart bit that clears front end state before its byte. Marks leave on
// the rsp_ stream: newline for every linebreak, paragraph on the second
// linebreak of a run, section on the third and later, and zero-length
// indent or dedent marks at the first content byte of a line. rsp_tlast
// flags the final mark of a byte; bytes that cause no mark give nothing.
// Throughput: one byte per cycle while the queue is not full. A linebreak
// that closes a paragraph or section gives two marks, and the output register
// sends one mark per cycle while rsp_tready is high; the four-entry mark queue
// between front and back absorbs short bursts of such bytes. A mark is
// written into the queue when its byte is accepted and then reaches rsp_
// through the output register. When the receiver stalls, the output register
// holds its mark, the queue fills, and req_tready drops only once it is full.
// Reset clears position, run and indentation state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module linebreak_indent_token_marker_core #(
   parameter int POS_BITS = litm_pkg::POS_BITS_DEFAULT,
   parameter int TAB_STOP = litm_pkg::TAB_STOP_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] ch, [8] restart, [15:9] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [31:0] start_pos, [47:32] mark_len,
                                         // [48] special, [55:49] zero
   output logic [2:0]       rsp_tuser,   // [2:0] kind
   output logic             rsp_tlast
);

   logic                   accept;
   logic                   push;
   litm_pkg::entry_type    push_entry;
   litm_pkg::entry_type    head;
   litm_pkg::q_status_type status;
   logic                   pop;
   litm_pkg::mark_type     out_mark;

   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;

   litm_front #(
      .POS_BITS (POS_BITS),
      .TAB_STOP (TAB_STOP)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .ch      (req_tdata[7:0]),
      .restart (req_tdata[8]),
      .push    (push),
      .entry   (push_entry)
   );

   litm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   litm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_mark  (out_mark),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {7'd0, out_mark.special, out_mark.mark_len, out_mark.start_pos};
   assign rsp_tuser = out_mark.kind;

endmodule
`default_nettype wire

[test/linebreak_indent_token_marker_core_tb.sv]
// Testbench for linebreak_indent_token_marker_core: text bytes in, line and indent marks out.
// A directed table, deep indentation, a linebreak run and random text are scored against
// a mark tracker kept here. Depends on litm_pkg and the core RTL.
`timescale 1ns / 1ps
module linebreak_indent_token_marker_core_tb;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_BYTES = 1220;
   localparam int DEEP_TABS    = 40;
   localparam int LONG_RUN     = 60;
   localparam int PREDICTED    = -1;
   localparam int SCRIPT_ROWS  = 24;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] start_pos;
      logic [15:0] mark_len;
      logic        special;
      logic        last;
   } text_mark_type;

   typedef struct {
      logic [7:0]  ch;
      logic        rst;
      int          typed;
      logic [2:0]  k0;
      int          s0;
      int          l0;
      logic [2:0]  k1;
      int          s1;
      int          l1;
   } script_row_type;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_SPARSE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   text_mark_type  marks_due[$];
   script_row_type script[SCRIPT_ROWS];
   int             errors = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             mode_left = 0;
   rx_mode_type    rx_mode = RX_OPEN;

   // mark tracker state
   logic [31:0] tr_pos;
   logic [31:0] tr_run_begin;
   logic [1:0]  tr_breaks;
   logic [15:0] tr_indent;
   logic [15:0] tr_indent_prev;

   linebreak_indent_token_marker_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic text_mark_type mark_of(logic [2:0] k, logic [31:0] s, logic [15:0] l);
      text_mark_type m;
      m.kind      = k;
      m.start_pos = s;
      m.mark_len  = l;
      m.special   = (k == litm_pkg::KIND_INDENT || k == litm_pkg::KIND_DEDENT);
      m.last      = 1'b0;
      return m;
   endfunction

   // Append one mark to the list of marks still to come.
   task automatic queue_mark(input text_mark_type m);
      marks_due.insert(marks_due.size(), m);
   endtask

   task automatic clear_tracker();
      tr_pos         = '0;
      tr_run_begin   = '0;
      tr_breaks      = 2'd1;
      tr_indent      = '0;
      tr_indent_prev = '0;
   endtask

   // Advance the tracker by one byte; queue its marks when asked.
   task automatic predict_marks(input logic [7:0] ch, input logic rst, input bit queue_it);
      logic [31:0]   p;
      logic          is_brk;
      logic          is_ws;
      logic [32:0]   span;
      logic [16:0]   step;
      text_mark_type found[2];
      int            n;
      n = 0;
      if (rst) clear_tracker();
      p = tr_pos;
      if (p != 32'hFFFF_FFFF) tr_pos = p + 32'd1;
      is_brk = (ch == litm_pkg::CH_LF || ch == litm_pkg::CH_CR);
      is_ws  = is_brk || ch == litm_pkg::CH_SPACE || ch == litm_pkg::CH_TAB;
      if (is_brk) begin
         found[n] = mark_of(litm_pkg::KIND_NEWLINE, p, 16'd1);
         n++;
         if (tr_breaks == 2'd0) tr_run_begin = p;
         tr_indent = '0;
         if (tr_breaks != 2'd3) tr_breaks = tr_breaks + 2'd1;
         span = (p >= tr_run_begin) ? {1'b0, p} - {1'b0, tr_run_begin} + 33'd1 : 33'd0;
         if (span > 33'(litm_pkg::LEN_MAX)) span = 33'(litm_pkg::LEN_MAX);
         if (tr_breaks == 2'd2) begin
            found[n] = mark_of(litm_pkg::KIND_PARAGRAPH, tr_run_begin, span[15:0]);
            n++;
         end else if (tr_breaks == 2'd3) begin
            found[n] = mark_of(litm_pkg::KIND_SECTION, tr_run_begin, span[15:0]);
            n++;
         end
      end else if (is_ws && tr_breaks != 2'd0) begin
         if (ch == litm_pkg::CH_TAB)
            step = 17'({1'b0, tr_indent} + litm_pkg::TAB_STOP_DEFAULT
                       - (tr_indent % litm_pkg::TAB_STOP_DEFAULT));
         else
            step = {1'b0, tr_indent} + 17'd1;
         tr_indent = (step > 17'(litm_pkg::IND_MAX)) ? litm_pkg::IND_MAX : step[15:0];
      end
      if (!is_ws && tr_breaks != 2'd0) begin
         if (tr_indent > tr_indent_prev) begin
            found[n] = mark_of(litm_pkg::KIND_INDENT, p, 16'd0);
            n++;
         end else if (tr_indent < tr_indent_prev) begin
            found[n] = mark_of(litm_pkg::KIND_DEDENT, p, 16'd0);
            n++;
         end
         tr_indent_prev = tr_indent;
         tr_breaks      = 2'd0;
      end
      if (queue_it) begin
         for (int i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            queue_mark(found[i]);
         end
      end
   endtask

   // Send one byte in bursts with random gaps; track it once the request is taken.
   task automatic send_byte(input logic [7:0] ch, input logic rst, input bit queue_it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 256)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tdata  <= {7'd0, rst, ch};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_marks(ch, rst, queue_it);
   endtask

   // Hold requests until every queued mark has come out.
   task automatic wait_drained();
      if (marks_due.size() != 0) begin
         req_tvalid <= 1'b0;
         while (marks_due.size() != 0) @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // receiver stall pattern: modes held for random stretches, one always ready
   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(32, 400);
      end else begin
         mode_left--;
      end
      unique case (rx_mode)
         RX_OPEN:  rsp_tready <= 1'b1;
         RX_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_HALF:  rsp_tready <= ($urandom_range(0, 1) != 0);
         default:  rsp_tready <= (mode_left % 4 == 0);
      endcase
   end

   always @(posedge clock) begin
      text_mark_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (marks_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected mark, expected none, actual kind %0d pos %0d",
                     $time, rsp_tuser, rsp_tdata[31:0]);
         end else begin
            want = marks_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("start_pos", want.start_pos, rsp_tdata[31:0]);
            check_field("mark_len", 32'(want.mark_len), 32'(rsp_tdata[47:32]));
            check_field("special", 32'(want.special), 32'(rsp_tdata[48]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("linebreak_indent_token_marker_core test failed");
         $finish;
      end
   end

   initial begin
      int            sent;
      int            tabs;
      int            spaces;
      int            body;
      int            lbs;
      bit            spaces_first;
      logic          rst_now;
      logic [7:0]    b;
      text_mark_type m;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      clear_tracker();

      // start of stream counts as after a linebreak; typed rows read straight off that
      script[0]  = '{litm_pkg::CH_LF, 1'b0, 2, litm_pkg::KIND_NEWLINE, 0, 1,
                     litm_pkg::KIND_PARAGRAPH, 0, 1};
      script[1]  = '{litm_pkg::CH_CR, 1'b0, 2, litm_pkg::KIND_NEWLINE, 1, 1,
                     litm_pkg::KIND_SECTION, 0, 2};
      script[2]  = '{litm_pkg::CH_LF, 1'b0, 2, litm_pkg::KIND_NEWLINE, 2, 1,
                     litm_pkg::KIND_SECTION, 0, 3};
      script[3]  = '{"A", 1'b0, 0, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[4]  = '{litm_pkg::CH_SPACE, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[5]  = '{litm_pkg::CH_LF, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[6]  = '{litm_pkg::CH_SPACE, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[7]  = '{litm_pkg::CH_TAB, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[8]  = '{"x", 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[9]  = '{litm_pkg::CH_LF, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[10] = '{litm_pkg::CH_TAB, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[11] = '{8'hFF, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[12] = '{litm_pkg::CH_CR, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[13] = '{"a", 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[14] = '{8'h00, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[15] = '{"b", 1'b1, 0, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[16] = '{litm_pkg::CH_LF, 1'b1, 2, litm_pkg::KIND_NEWLINE, 0, 1,
                     litm_pkg::KIND_PARAGRAPH, 0, 1};
      script[17] = '{8'h80, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[18] = '{litm_pkg::CH_CR, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[19] = '{litm_pkg::CH_CR, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[20] = '{litm_pkg::CH_TAB, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[21] = '{litm_pkg::CH_SPACE, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[22] = '{8'h7F, 1'b0, PREDICTED, litm_pkg::KIND_NEWLINE, 0, 0,
                     litm_pkg::KIND_NEWLINE, 0, 0};
      script[23] = '{litm_pkg::CH_LF, 1'b1, 2, litm_pkg::KIND_NEWLINE, 0, 1,
                     litm_pkg::KIND_PARAGRAPH, 0, 1};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].typed == PREDICTED) begin
            send_byte(script[i].ch, script[i].rst, 1'b1);
         end else begin
            if (script[i].typed > 0) begin
               m      = mark_of(script[i].k0, 32'(script[i].s0), 16'(script[i].l0));
               m.last = (script[i].typed == 1);
               queue_mark(m);
            end
            if (script[i].typed > 1) begin
               m      = mark_of(script[i].k1, 32'(script[i].s1), 16'(script[i].l1));
               m.last = 1'b1;
               queue_mark(m);
            end
            send_byte(script[i].ch, script[i].rst, 1'b0);
         end
      end
      wait_drained();

      // indent deeply with tabs and a space, then drop back to column zero
      send_byte(litm_pkg::CH_LF, 1'b0, 1'b1);
      repeat (DEEP_TABS) send_byte(litm_pkg::CH_TAB, 1'b0, 1'b1);
      send_byte(litm_pkg::CH_SPACE, 1'b0, 1'b1);
      send_byte("q", 1'b0, 1'b1);
      send_byte(litm_pkg::CH_LF, 1'b0, 1'b1);
      send_byte("r", 1'b0, 1'b1);
      wait_drained();

      // one long linebreak run of mixed line feeds and carriage returns
      repeat (LONG_RUN)
         send_byte(($urandom_range(0, 1) != 0) ? litm_pkg::CH_LF : litm_pkg::CH_CR,
                   1'b0, 1'b1);
      send_byte("z", 1'b0, 1'b1);
      wait_drained();

      sent   = 0;
      tabs   = 0;
      spaces = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0), 1'b1);
            sent++;
         end else begin
            rst_now = ($urandom_range(0, 39) == 0);
            // keep the last indentation a third of the time so equal lines occur
            if ($urandom_range(0, 2) != 0) begin
               tabs   = $urandom_range(0, 3);
               spaces = $urandom_range(0, 5);
            end
            spaces_first = ($urandom_range(0, 1) != 0);
            for (int k = 0; k < tabs + spaces; k++) begin
               if (spaces_first) b = (k < spaces) ? litm_pkg::CH_SPACE : litm_pkg::CH_TAB;
               else b = (k < tabs) ? litm_pkg::CH_TAB : litm_pkg::CH_SPACE;
               send_byte(b, rst_now, 1'b1);
               rst_now = 1'b0;
               sent++;
            end
            body = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            for (int k = 0; k < body; k++) begin
               do b = 8'($urandom_range(0, 255));
               while (b == litm_pkg::CH_LF || b == litm_pkg::CH_CR ||
                      (k == 0 && (b == litm_pkg::CH_SPACE || b == litm_pkg::CH_TAB)));
               send_byte(b, rst_now, 1'b1);
               rst_now = 1'b0;
               sent++;
            end
            lbs = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
            for (int k = 0; k < lbs; k++) begin
               send_byte(($urandom_range(0, 1) != 0) ? litm_pkg::CH_LF : litm_pkg::CH_CR,
                         rst_now, 1'b1);
               rst_now = 1'b0;
               sent++;
            end
         end
         if ($urandom_range(0, 99) == 0) wait_drained();
      end

      req_tvalid <= 1'b0;
      while (marks_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0 && marks_due.size() == 0) begin
         $display("linebreak_indent_token_marker_core test passed");
      end else begin
         $display("linebreak_indent_token_marker_core test failed");
      end
      $finish;
   end

endmodule
